// File: hdl/rwc_pkg.sv
`default_nettype none
package rwc_pkg;
   localparam int KERNEL_HEIGHT_DEF = 3;
   localparam int KERNEL_WIDTH_DEF  = 3;
   localparam int ROWS_IN   = 3;
   localparam int CHANNELS  = 3;
   localparam int WEIGHT_W  = 16;
   localparam int SAMPLE_W  = 8;
   localparam int SUM_W     = 32;
   localparam int DIV_W     = 16;
   localparam int QUO_W     = SUM_W;

   typedef enum logic [1:0] {
      CSR_WEIGHTS_ROW0 = 2'd0,
      CSR_WEIGHTS_ROW1 = 2'd1,
      CSR_WEIGHTS_ROW2 = 2'd2,
      CSR_DIVISOR      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_OUTPUT = 2'd2
   } state_type;
endpackage
`default_nettype wire

// File: hdl/rwc_lane.sv
`default_nettype none
// One color channel: weighted sum over the window, then restoring divide.
module rwc_lane
   import rwc_pkg::*;
#(
   parameter int KERNEL_HEIGHT = KERNEL_HEIGHT_DEF,
   parameter int KERNEL_WIDTH  = KERNEL_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [KERNEL_WIDTH*ROWS_IN*SAMPLE_W-1:0] samples,
   input  wire logic [3*3*WEIGHT_W-1:0] weights,
   input  wire logic [DIV_W-1:0] divisor,
   output logic done,
   output logic [SAMPLE_W-1:0] result
);
   localparam int TERMS = KERNEL_WIDTH * ROWS_IN;
   localparam int CNT_W = $clog2(TERMS + QUO_W + 2);
   localparam int ROW_W = $clog2(ROWS_IN + 1);
   localparam int COLS_W = $clog2(KERNEL_WIDTH + 1);

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_W:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COLS_W-1:0] col_ff, col_in;
   logic busy_ff, busy_in, phase_ff, phase_in, neg_ff, neg_in;
   logic signed [SUM_W-1:0] prod;
   logic [DIV_W:0] trial;
   logic [DIV_W-1:0] dv;
   logic [SAMPLE_W-1:0] res_ff, res_in;
   logic done_ff, done_in;

   assign dv = (divisor == '0) ? DIV_W'(1) : divisor;

   // One multiply-accumulate per cycle: term index = col*ROWS_IN + row.
   always_comb begin
      logic [$clog2(TERMS+1)-1:0] t;
      logic signed [WEIGHT_W-1:0] w;
      t = cnt_ff[$clog2(TERMS+1)-1:0];
      w = '0;
      if (int'(col_ff) < 3 && int'(row_ff) < KERNEL_HEIGHT)
         w = weights[(int'(row_ff)*3 + int'(col_ff))*WEIGHT_W +: WEIGHT_W];
      prod = SUM_W'(w) * SUM_W'(signed'({1'b0, samples[t*SAMPLE_W +: SAMPLE_W]}));
   end

   always_comb begin
      sum_in = sum_ff; quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      row_in = row_ff; col_in = col_ff;
      busy_in = busy_ff; phase_in = phase_ff; neg_in = neg_ff;
      res_in = res_ff; done_in = 1'b0;
      trial = {rem_ff[DIV_W-1:0], quo_ff[QUO_W-1]};
      if (start) begin
         busy_in = 1'b1; phase_in = 1'b0; sum_in = '0; cnt_in = '0;
         row_in = '0; col_in = '0;
      end else if (busy_ff && !phase_ff) begin
         sum_in = sum_ff + prod;
         cnt_in = cnt_ff + 1'b1;
         if (row_ff == ROW_W'(ROWS_IN - 1)) begin
            row_in = '0; col_in = col_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
         if (cnt_ff == CNT_W'(TERMS - 1)) begin
            phase_in = 1'b1; cnt_in = '0;
            neg_in = sum_in[SUM_W-1];
            quo_in = QUO_W'(sum_in); rem_in = '0;
         end
      end else if (busy_ff) begin
         // Restoring division, one quotient bit per cycle.
         quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         rem_in = trial;
         if (trial >= {1'b0, dv}) begin
            rem_in = trial - {1'b0, dv};
            quo_in[0] = 1'b1;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
            if (neg_ff) res_in = '0;
            else if (quo_in > QUO_W'(255)) res_in = 8'd255;
            else res_in = quo_in[SAMPLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; phase_ff <= 1'b0; cnt_ff <= '0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; phase_ff <= phase_in; cnt_ff <= cnt_in; done_ff <= done_in;
      end
      sum_ff <= sum_in; quo_ff <= quo_in; rem_ff <= rem_in;
      neg_ff <= neg_in; res_ff <= res_in;
      row_ff <= row_in; col_ff <= col_in;
   end

   assign done = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

// File: hdl/rgb24_window_convolution.sv
`default_nettype none
// Timing: an item that completes a window is registered as the lane start; the lanes then
// accumulate and divide, and their registered done raises rsp_tvalid. Items that only fill
// the window are taken while idle and can be followed by the next item on the next cycle.
// Flow: one item at a time; req_tready stays low from an emitting item's accept until the
// per-lane serial MAC and divider finish and the receiver takes the result.
// Reset (synchronous, active high) clears the window, column count, registers
// to their defaults (center weight 1, divisor 1) and the output handshake.
module rgb24_window_convolution
   import rwc_pkg::*;
#(
   parameter int KERNEL_HEIGHT = KERNEL_HEIGHT_DEF,
   parameter int KERNEL_WIDTH  = KERNEL_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // row0 r,g,b; row1 r,g,b; row2 r,g,b
   input  wire logic [71:0] req_tdata,
   input  wire logic req_tlast,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // out_red, out_green, out_blue
   output logic [23:0] rsp_tdata,
   output logic rsp_tlast,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [47:0] csr_data
);
   localparam int COL_W = ROWS_IN*CHANNELS*SAMPLE_W;
   localparam int CH_W  = $clog2(KERNEL_WIDTH + 1);

   logic [47:0] w0_ff, w1_ff, w2_ff;
   logic [DIV_W-1:0] div_ff;
   logic [COL_W-1:0] win_ff [KERNEL_WIDTH];
   logic [COL_W-1:0] win_in [KERNEL_WIDTH];
   logic [CH_W-1:0] held_ff, held_in;
   state_type state_ff, state_in;
   logic last_ff, last_in;
   logic [23:0] out_ff, out_in;
   logic [CHANNELS-1:0] lane_done;
   logic [SAMPLE_W-1:0] lane_res [CHANNELS];
   logic [KERNEL_WIDTH*ROWS_IN*SAMPLE_W-1:0] lane_smp [CHANNELS];
   logic accept, emit;
   logic [CH_W-1:0] pos;
   logic start_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff <= '0; w1_ff <= 48'h10000; w2_ff <= '0; div_ff <= DIV_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WEIGHTS_ROW0: w0_ff <= csr_data;
            CSR_WEIGHTS_ROW1: w1_ff <= csr_data;
            CSR_WEIGHTS_ROW2: w2_ff <= csr_data;
            CSR_DIVISOR:      div_ff <= csr_data[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign pos = (held_ff > CH_W'(KERNEL_WIDTH-1)) ? CH_W'(KERNEL_WIDTH-1) : held_ff;
   assign emit = accept && (pos == CH_W'(KERNEL_WIDTH-1));

   // Write the new column at pos; shift left when the emitted result is taken.
   always_comb begin
      for (int c = 0; c < KERNEL_WIDTH; c++) win_in[c] = win_ff[c];
      held_in = held_ff;
      if (accept) begin
         for (int c = 0; c < KERNEL_WIDTH; c++)
            if (CH_W'(c) == pos) win_in[c] = req_tdata;
         held_in = emit ? CH_W'(KERNEL_WIDTH-1) : pos + 1'b1;
         if (req_tlast) held_in = '0;
      end
      if (state_ff == ST_OUTPUT && rsp_tready)
         for (int c = 0; c + 1 < KERNEL_WIDTH; c++) win_in[c] = win_ff[c+1];
   end

   // Gather per-channel samples, term index col*ROWS_IN + row.
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++)
         for (int c = 0; c < KERNEL_WIDTH; c++)
            for (int r = 0; r < ROWS_IN; r++)
               lane_smp[ch][(c*ROWS_IN+r)*SAMPLE_W +: SAMPLE_W] =
                  win_ff[c][(r*CHANNELS+ch)*SAMPLE_W +: SAMPLE_W];
   end

   always_comb begin
      state_in = state_ff; last_in = last_ff; out_in = out_ff;
      unique case (state_ff)
         ST_IDLE: if (emit) begin
            state_in = ST_DIVIDE; last_in = req_tlast;
         end
         ST_DIVIDE: begin
            if (lane_done[0]) begin
               state_in = ST_OUTPUT;
               out_in = {lane_res[2], lane_res[1], lane_res[0]};
            end
         end
         ST_OUTPUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; held_ff <= '0; start_ff <= 1'b0;
         for (int c = 0; c < KERNEL_WIDTH; c++) win_ff[c] <= '0;
      end else begin
         state_ff <= state_in; held_ff <= held_in; start_ff <= emit;
         for (int c = 0; c < KERNEL_WIDTH; c++) win_ff[c] <= win_in[c];
      end
      last_ff <= last_in; out_ff <= out_in;
   end

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      rwc_lane #(.KERNEL_HEIGHT(KERNEL_HEIGHT), .KERNEL_WIDTH(KERNEL_WIDTH)) u_lane (
         .clock(clock), .reset(reset), .start(start_ff),
         .samples(lane_smp[ch]),
         .weights({w2_ff, w1_ff, w0_ff}),
         .divisor(div_ff),
         .done(lane_done[ch]), .result(lane_res[ch]));
   end

   assign rsp_tvalid = (state_ff == ST_OUTPUT);
   assign rsp_tdata = out_ff;
   assign rsp_tlast = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      emit |=> state_ff == ST_DIVIDE) else $error("emit did not start divide");
   assert property (@(posedge clock) disable iff (reset)
      lane_done != '0 |-> lane_done == {CHANNELS{1'b1}}) else $error("lanes out of step");
   assert property (@(posedge clock) disable iff (reset)
      held_ff <= CH_W'(KERNEL_WIDTH-1)) else $error("column count overflow");
endmodule
`default_nettype wire
